@@ hw/rtl/pwlo_pkg.sv @@
// Package for the pixel window/level/orientation block.
// Holds field widths, register codes, reset values and the configuration struct.
// No dependencies; every other file imports it.
package pwlo_pkg;

   // Stream payload widths
   localparam int PIXEL_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int DEST_W      = 24;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 64;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // Register field widths
   localparam int ORIENT_W = 3;
   localparam int SIZE_W   = 13;
   localparam int GAIN_W   = 25;
   localparam int SAT_W    = 17;
   localparam int DIFF_W   = PIXEL_W + 1;

   // Parameter defaults
   localparam int MAX_DIM_DEFAULT        = 4096;
   localparam int GAIN_FRAC_BITS_DEFAULT = 16;

   // Display value for saturated pixels
   localparam logic [BYTE_W-1:0] BYTE_FULL = 8'd255;

   // Orientation bits
   localparam int ORIENT_TRANSPOSE = 0;
   localparam int ORIENT_FLIP_SLOW = 1;
   localparam int ORIENT_FLIP_FAST = 2;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [REG_IDX_W-1:0] {
      REG_ORIENTATION      = 3'd0,
      REG_FRAME_WIDTH      = 3'd1,
      REG_FRAME_HEIGHT     = 3'd2,
      REG_BLACK_LEVEL      = 3'd3,
      REG_GAIN             = 3'd4,
      REG_SATURATION_LEVEL = 3'd5,
      REG_MAX_LEVEL        = 3'd6
   } reg_index_type;

   // Reset values
   localparam logic [ORIENT_W-1:0]      ORIENT_RESET = 3'd0;
   localparam logic [SIZE_W-1:0]        SIZE_RESET   = 13'd1;
   localparam logic [PIXEL_W-1:0]       BLACK_RESET  = 16'd0;
   localparam logic signed [GAIN_W-1:0] GAIN_RESET   = 25'sd65536;
   localparam logic [SAT_W-1:0]         SAT_RESET    = 17'd65536;
   localparam logic [BYTE_W-1:0]        MAX_RESET    = 8'd255;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [ORIENT_W-1:0]      orientation;
      logic [SIZE_W-1:0]        frame_width;
      logic [SIZE_W-1:0]        frame_height;
      logic [PIXEL_W-1:0]       black_level;
      logic signed [GAIN_W-1:0] gain;
      logic [SAT_W-1:0]         saturation_level;
      logic [BYTE_W-1:0]        max_level;
   } cfg_type;

endpackage

@@ hw/rtl/pwlo_regs.sv @@
// Configuration register file with an APB-style slave port.
// Depends on pwlo_pkg for register codes, widths and reset values.
module pwlo_regs
   import pwlo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // Decode the write; unknown indexes leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ORIENTATION:      cfg_in.orientation      = csr_pwdata[ORIENT_W-1:0];
            REG_FRAME_WIDTH:      cfg_in.frame_width      = csr_pwdata[SIZE_W-1:0];
            REG_FRAME_HEIGHT:     cfg_in.frame_height     = csr_pwdata[SIZE_W-1:0];
            REG_BLACK_LEVEL:      cfg_in.black_level      = csr_pwdata[PIXEL_W-1:0];
            REG_GAIN:             cfg_in.gain             = $signed(csr_pwdata[GAIN_W-1:0]);
            REG_SATURATION_LEVEL: cfg_in.saturation_level = csr_pwdata[SAT_W-1:0];
            REG_MAX_LEVEL:        cfg_in.max_level        = csr_pwdata[BYTE_W-1:0];
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.orientation      <= ORIENT_RESET;
         cfg_ff.frame_width      <= SIZE_RESET;
         cfg_ff.frame_height     <= SIZE_RESET;
         cfg_ff.black_level      <= BLACK_RESET;
         cfg_ff.gain             <= GAIN_RESET;
         cfg_ff.saturation_level <= SAT_RESET;
         cfg_ff.max_level        <= MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register; gain sign-extends
   always_comb begin
      case (reg_idx)
         REG_ORIENTATION:      csr_prdata = CSR_DATA_W'(cfg_ff.orientation);
         REG_FRAME_WIDTH:      csr_prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:     csr_prdata = CSR_DATA_W'(cfg_ff.frame_height);
         REG_BLACK_LEVEL:      csr_prdata = CSR_DATA_W'(cfg_ff.black_level);
         REG_GAIN:             csr_prdata = CSR_DATA_W'(cfg_ff.gain);
         REG_SATURATION_LEVEL: csr_prdata = CSR_DATA_W'(cfg_ff.saturation_level);
         REG_MAX_LEVEL:        csr_prdata = CSR_DATA_W'(cfg_ff.max_level);
         default:              csr_prdata = '0;
      endcase
   end

endmodule

@@ hw/rtl/pwlo_scale.sv @@
// Window/level of one pixel to a display byte: saturate, offset, gain, clamp, round.
// Depends on pwlo_pkg for widths and the configuration struct.
module pwlo_scale
   import pwlo_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input  logic [PIXEL_W-1:0] pixel,
   input  cfg_type            cfg,
   output logic [BYTE_W-1:0]  display_byte
);

   localparam int PROD_W  = DIFF_W + GAIN_W;
   localparam int CLAMP_W = BYTE_W + GAIN_FRAC_BITS;
   localparam logic [CLAMP_W:0] HALF = (CLAMP_W + 1)'(1) << (GAIN_FRAC_BITS - 1);

   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  prod;
   logic [CLAMP_W-1:0]        top;
   logic [CLAMP_W-1:0]        clamped;
   logic [CLAMP_W:0]          rounded;
   logic                      saturated;

   // Offset by black level, then multiply by the signed Q gain
   assign diff = $signed({1'b0, pixel}) - $signed({1'b0, cfg.black_level});
   assign prod = diff * cfg.gain;
   assign top  = {cfg.max_level, GAIN_FRAC_BITS'(0)};

   // Clamp to 0..max_level in fixed point
   always_comb begin
      if (prod[PROD_W-1]) begin
         clamped = '0;
      end else if ($unsigned(prod) > PROD_W'(top)) begin
         clamped = top;
      end else begin
         clamped = prod[CLAMP_W-1:0];
      end
   end

   // Round half up and drop the fraction
   assign rounded   = {1'b0, clamped} + HALF;
   assign saturated = {1'b0, pixel} >= cfg.saturation_level;

   assign display_byte = saturated ? BYTE_FULL : rounded[GAIN_FRAC_BITS +: BYTE_W];

endmodule

@@ hw/rtl/pixel_window_level_orient_top.sv @@
// Top level of the pixel window/level/orientation block.
// Depends on pwlo_pkg, pwlo_regs and pwlo_scale.
//
// channel   direction  handshake        payload
// req       in         tvalid/tready    tdata: pixel
// rsp       out        tvalid/tready    tdata: display_byte, dest_index, frame_min,
//                                       frame_max; tlast: frame_end
// csr       in         APB write/read   seven registers at byte address 4*index
//
// One pixel per clock if rsp does not stall; stage 1 feeds the output register.
// The input stage updates the counters and the running min/max and registers the
// index operands; the second stage does the gain multiply and the index multiply.
// Reset (synchronous) empties both stages and clears counters and extremes.
// A stall on rsp backs up through the two stages; req_tready drops only when both
// are full and rsp_tready is low.
module pixel_window_level_orient_top
   import pwlo_pkg::*;
#(
   parameter int MAX_DIM        = MAX_DIM_DEFAULT,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel[15:0]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // display_byte[7:0], dest_index[31:8], frame_min[47:32], frame_max[63:48]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int SZ_W   = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;
   localparam int MUL_W  = CNT_W + DIM_W;
   localparam int IDX_W  = (MUL_W + 1 > DEST_W) ? MUL_W + 1 : DEST_W;

   cfg_type cfg;

   pwlo_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake and pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic req_xfer, s1_adv, out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   // Effective frame sizes: zero acts as one, oversize acts as MAX_DIM
   logic [SZ_W-1:0]  w_ext, h_ext;
   logic [DIM_W-1:0] w_eff, h_eff;

   assign w_ext = SZ_W'(cfg.frame_width);
   assign h_ext = SZ_W'(cfg.frame_height);

   always_comb begin
      if (w_ext == '0) begin
         w_eff = DIM_W'(1);
      end else if (w_ext > SZ_W'(MAX_DIM)) begin
         w_eff = DIM_W'(MAX_DIM);
      end else begin
         w_eff = w_ext[DIM_W-1:0];
      end
      if (h_ext == '0) begin
         h_eff = DIM_W'(1);
      end else if (h_ext > SZ_W'(MAX_DIM)) begin
         h_eff = DIM_W'(MAX_DIM);
      end else begin
         h_eff = h_ext[DIM_W-1:0];
      end
   end

   // Position counters and running extremes
   logic [CNT_W-1:0]   slow_ff, slow_in, fast_ff, fast_in;
   logic [PIXEL_W-1:0] run_min_ff, run_min_in, run_max_ff, run_max_in;
   logic [DIM_W-1:0]   i_ext, j_ext, i_cl, j_cl, i_next, j_next;
   logic [DIM_W-1:0]   ii_full, jj_full;
   logic [CNT_W-1:0]   ii, jj;
   logic               row_end, frame_end, first_px;
   logic [PIXEL_W-1:0] px;

   assign px       = req_tdata[PIXEL_W-1:0];
   assign i_ext    = DIM_W'(slow_ff);
   assign j_ext    = DIM_W'(fast_ff);
   assign i_cl     = (i_ext >= w_eff) ? w_eff - DIM_W'(1) : i_ext;
   assign j_cl     = (j_ext >= h_eff) ? h_eff - DIM_W'(1) : j_ext;
   assign i_next   = i_cl + DIM_W'(1);
   assign j_next   = j_cl + DIM_W'(1);
   assign row_end  = j_next >= h_eff;
   assign frame_end = row_end && (i_next >= w_eff);
   assign first_px = (slow_ff == '0) && (fast_ff == '0);

   // Apply the flips
   assign ii_full = cfg.orientation[ORIENT_FLIP_SLOW] ? w_eff - DIM_W'(1) - i_cl : i_cl;
   assign jj_full = cfg.orientation[ORIENT_FLIP_FAST] ? h_eff - DIM_W'(1) - j_cl : j_cl;
   assign ii      = ii_full[CNT_W-1:0];
   assign jj      = jj_full[CNT_W-1:0];

   // Advance counters and extremes on each transfer
   always_comb begin
      slow_in    = slow_ff;
      fast_in    = fast_ff;
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      if (req_xfer) begin
         if (first_px) begin
            run_min_in = px;
            run_max_in = px;
         end else begin
            if (px < run_min_ff) run_min_in = px;
            if (px > run_max_ff) run_max_in = px;
         end
         if (frame_end) begin
            slow_in = '0;
            fast_in = '0;
         end else if (row_end) begin
            slow_in = i_next[CNT_W-1:0];
            fast_in = '0;
         end else begin
            slow_in = i_cl[CNT_W-1:0];
            fast_in = j_next[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_ff    <= '0;
         fast_ff    <= '0;
         run_min_ff <= '0;
         run_max_ff <= '0;
      end else begin
         slow_ff    <= slow_in;
         fast_ff    <= fast_in;
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
      end
   end

   // Stage 1 registers: pixel and index operands (multiplier, multiplicand, addend)
   logic [PIXEL_W-1:0] px1_ff, min1_ff, max1_ff;
   logic [CNT_W-1:0]   mul_a1_ff, add_c1_ff;
   logic [DIM_W-1:0]   mul_b1_ff;
   logic               last1_ff;

   assign s1_valid_in = req_xfer || (s1_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         px1_ff    <= px;
         min1_ff   <= run_min_in;
         max1_ff   <= run_max_in;
         last1_ff  <= frame_end;
         mul_a1_ff <= cfg.orientation[ORIENT_TRANSPOSE] ? jj : ii;
         mul_b1_ff <= cfg.orientation[ORIENT_TRANSPOSE] ? w_eff : h_eff;
         add_c1_ff <= cfg.orientation[ORIENT_TRANSPOSE] ? ii : jj;
      end
   end

   // Stage 2: scale the pixel and form the destination index
   logic [BYTE_W-1:0] scaled;
   logic [MUL_W-1:0]  dest_prod;
   logic [IDX_W-1:0]  dest_sum;

   pwlo_scale #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_scale (
      .pixel        (px1_ff),
      .cfg          (cfg),
      .display_byte (scaled)
   );

   assign dest_prod = mul_a1_ff * mul_b1_ff;
   assign dest_sum  = IDX_W'(dest_prod) + IDX_W'(add_c1_ff);

   // Output register
   logic [BYTE_W-1:0]  byte_ff;
   logic [DEST_W-1:0]  dest_ff;
   logic [PIXEL_W-1:0] min_ff, max_ff;
   logic               last_ff;

   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         byte_ff <= scaled;
         dest_ff <= dest_sum[DEST_W-1:0];
         min_ff  <= min1_ff;
         max_ff  <= max1_ff;
         last_ff <= last1_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {max_ff, min_ff, dest_ff, byte_ff};

   // Checks on the pipeline and the running state
   assert property (@(posedge clock) disable iff (reset)
      run_min_ff <= run_max_ff)
      else $error("running minimum above running maximum");

   assert property (@(posedge clock) disable iff (reset)
      req_xfer && frame_end |=> slow_ff == '0 && fast_ff == '0)
      else $error("counters not cleared after last pixel of frame");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(px1_ff))
      else $error("stage 1 item lost during output stall");

   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted pixel did not enter stage 1");

endmodule

@@ sim/pwlo_checker.sv @@
// Result checker for the pixel window/level/orientation block.
// Tracks CSR writes and accepted pixels, predicts each display result and compares it.
// Depends on pwlo_pkg.
module pwlo_checker
   import pwlo_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                   csr_pready,
   output int unsigned            pending_results,
   output int unsigned            mismatch_count,
   output int unsigned            results_seen,
   output int unsigned            frames_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS   = GAIN_FRAC_BITS_DEFAULT;
   localparam int DIM_LIMIT   = MAX_DIM_DEFAULT;

   typedef struct packed {
      logic [BYTE_W-1:0]  level;
      logic [DEST_W-1:0]  dest_index;
      logic               frame_end;
      logic [PIXEL_W-1:0] frame_min;
      logic [PIXEL_W-1:0] frame_max;
   } display_item_type;

   // Shadow of the register file and of the frame walk
   cfg_type       cfg;
   int unsigned   slow_cnt;
   int unsigned   fast_cnt;
   logic [PIXEL_W-1:0] run_lo;
   logic [PIXEL_W-1:0] run_hi;
   display_item_type expected_display_q[$];
   int unsigned   errors;
   int unsigned   checked;
   int unsigned   frames;

   task automatic report_mismatch(input string what, input longint unsigned want_v,
                                  input longint unsigned got_v);
      errors++;
      $display("%0t ns: %s mismatch at result %0d: expected 0x%0h, got 0x%0h",
               $realtime, what, checked, want_v, got_v);
   endtask

   function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] s);
      if (s == 0) return 1;
      if (s > DIM_LIMIT) return DIM_LIMIT;
      return 32'(s);
   endfunction

   // Window/level: saturate, offset by black level, scale by Q8.16 gain, clamp, round
   function automatic logic [BYTE_W-1:0] window_level(input logic [PIXEL_W-1:0] px);
      longint diff;
      longint prod;
      longint top;
      if ({1'b0, px} >= cfg.saturation_level) return BYTE_FULL;
      diff = longint'(px) - longint'(cfg.black_level);
      prod = diff * longint'($signed(cfg.gain));
      top  = longint'(cfg.max_level) <<< FRAC_BITS;
      if (prod < 0) prod = 0;
      else if (prod > top) prod = top;
      prod = (prod + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return prod[BYTE_W-1:0];
   endfunction

   // Predict one result and advance the frame counters and extremes
   function automatic display_item_type predict_display(input logic [PIXEL_W-1:0] px);
      display_item_type r;
      int unsigned   w;
      int unsigned   h;
      int unsigned   i;
      int unsigned   j;
      int unsigned   ii;
      int unsigned   jj;
      longint unsigned dest;
      logic          row_end;
      w = clamp_dim(cfg.frame_width);
      h = clamp_dim(cfg.frame_height);
      i = (slow_cnt >= w) ? w - 1 : slow_cnt;
      j = (fast_cnt >= h) ? h - 1 : fast_cnt;
      if (slow_cnt == 0 && fast_cnt == 0) begin
         run_lo = px;
         run_hi = px;
      end else begin
         if (px < run_lo) run_lo = px;
         if (px > run_hi) run_hi = px;
      end
      ii = cfg.orientation[ORIENT_FLIP_SLOW] ? w - 1 - i : i;
      jj = cfg.orientation[ORIENT_FLIP_FAST] ? h - 1 - j : j;
      if (cfg.orientation[ORIENT_TRANSPOSE])
         dest = longint'(jj) * w + ii;
      else
         dest = longint'(ii) * h + jj;
      row_end      = (j + 1 >= h);
      r.level      = window_level(px);
      r.dest_index = dest[DEST_W-1:0];
      r.frame_end  = row_end && (i + 1 >= w);
      r.frame_min  = run_lo;
      r.frame_max  = run_hi;
      // Walk fast index first, then slow; wrap at frame end
      if (r.frame_end) begin
         slow_cnt = 0;
         fast_cnt = 0;
      end else if (row_end) begin
         fast_cnt = 0;
         slow_cnt = i + 1;
      end else begin
         fast_cnt = j + 1;
         slow_cnt = i;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      display_item_type want;
      display_item_type got;
      if (reset) begin
         cfg.orientation      = ORIENT_RESET;
         cfg.frame_width      = SIZE_RESET;
         cfg.frame_height     = SIZE_RESET;
         cfg.black_level      = BLACK_RESET;
         cfg.gain             = GAIN_RESET;
         cfg.saturation_level = SAT_RESET;
         cfg.max_level        = MAX_RESET;
         slow_cnt = 0;
         fast_cnt = 0;
         run_lo   = '0;
         run_hi   = '0;
         expected_display_q.delete();
      end else begin
         // Compare each result transfer with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.level      = rsp_tdata[7:0];
            got.dest_index = rsp_tdata[31:8];
            got.frame_min  = rsp_tdata[47:32];
            got.frame_max  = rsp_tdata[63:48];
            got.frame_end  = rsp_tlast;
            if (expected_display_q.size() == 0) begin
               report_mismatch("unexpected result", 0, rsp_tdata);
            end else begin
               want = expected_display_q.pop_front();
               if (got.level !== want.level)
                  report_mismatch("display byte", want.level, got.level);
               if (got.dest_index !== want.dest_index)
                  report_mismatch("dest index", want.dest_index, got.dest_index);
               if (got.frame_end !== want.frame_end)
                  report_mismatch("frame end", want.frame_end, got.frame_end);
               if (got.frame_min !== want.frame_min)
                  report_mismatch("frame min", want.frame_min, got.frame_min);
               if (got.frame_max !== want.frame_max)
                  report_mismatch("frame max", want.frame_max, got.frame_max);
            end
            if (rsp_tlast === 1'b1) frames++;
            checked++;
         end
         // Predict each accepted pixel
         if (req_tvalid && req_tready)
            expected_display_q.push_back(predict_display(req_tdata[PIXEL_W-1:0]));
         // Mirror register writes; unknown indexes are dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               REG_ORIENTATION:      cfg.orientation      = csr_pwdata[ORIENT_W-1:0];
               REG_FRAME_WIDTH:      cfg.frame_width      = csr_pwdata[SIZE_W-1:0];
               REG_FRAME_HEIGHT:     cfg.frame_height     = csr_pwdata[SIZE_W-1:0];
               REG_BLACK_LEVEL:      cfg.black_level      = csr_pwdata[PIXEL_W-1:0];
               REG_GAIN:             cfg.gain             = csr_pwdata[GAIN_W-1:0];
               REG_SATURATION_LEVEL: cfg.saturation_level = csr_pwdata[SAT_W-1:0];
               REG_MAX_LEVEL:        cfg.max_level        = csr_pwdata[BYTE_W-1:0];
               default: ;
            endcase
         end
      end
      pending_results <= expected_display_q.size();
      mismatch_count  <= errors;
      results_seen    <= checked;
      frames_seen     <= frames;
   end

endmodule

@@ sim/tb_pixel_window_level_orient_top.sv @@
// Testbench top for the pixel window/level/orientation block.
// Drives pixels, CSR writes and result backpressure; pwlo_checker does the predicting.
// Depends on pwlo_pkg, pwlo_checker and the block's RTL.
module tb_pixel_window_level_orient_top
   import pwlo_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PIXEL_COUNT = 950;
   localparam int unsigned CALM_TAIL   = 150;
   localparam int unsigned HOLD_CYCLES = 48;
   localparam logic [CSR_ADDR_W-1:0] UNUSED_REG_ADDR = 5'd28;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   // pixel[15:0]
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   // display_byte[7:0], dest_index[31:8], frame_min[47:32], frame_max[63:48]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int unsigned pending_results;
   int unsigned mismatch_count;
   int unsigned results_seen;
   int unsigned frames_seen;
   int unsigned pixels_sent = 0;
   int unsigned phases_run  = 0;

   bit gaps_on   = 1'b0;
   bit stalls_on = 1'b0;
   bit hold_off  = 1'b0;

   pixel_window_level_orient_top i_dut (.*);

   pwlo_checker i_display_check (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400_000;
      $display("pixel_window_level_orient_top test failed");
      $finish;
   end

   // APB write: setup cycle, then access cycle
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input logic [2:0] ori, input logic [12:0] w, input logic [12:0] h,
                            input logic [15:0] blk, input logic [24:0] g,
                            input logic [16:0] sat, input logic [7:0] mx);
      csr_write({REG_ORIENTATION, 2'b00}, {29'd0, ori});
      csr_write({REG_FRAME_WIDTH, 2'b00}, {19'd0, w});
      csr_write({REG_FRAME_HEIGHT, 2'b00}, {19'd0, h});
      csr_write({REG_BLACK_LEVEL, 2'b00}, {16'd0, blk});
      csr_write({REG_GAIN, 2'b00}, {7'd0, g});
      csr_write({REG_SATURATION_LEVEL, 2'b00}, {15'd0, sat});
      csr_write({REG_MAX_LEVEL, 2'b00}, {24'd0, mx});
   endtask

   // Offer one pixel, with an optional idle burst first; return at the transfer edge
   task automatic send_pixel(input logic [15:0] px);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      phases_run++;
   endtask

   function automatic logic [12:0] pick_dim();
      case ($urandom_range(0, 19))
         0:       return 13'd0;
         1:       return 13'($urandom_range(4097, 8191));
         2:       return 13'($urandom_range(1, 8191));
         3:       return 13'd4096;
         default: return 13'($urandom_range(1, 6));
      endcase
   endfunction

   // Mostly pixels inside the display window, some noise and edge values
   function automatic logic [15:0] pick_pixel(input logic [15:0] blk, input int unsigned span,
                                              input logic [16:0] sat);
      int unsigned v;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 65535);
         1: begin
            case ($urandom_range(0, 4))
               0:       v = 0;
               1:       v = 65535;
               2:       v = 32'(blk);
               3:       v = 32'(sat);
               default: v = 32'(sat) - 1;
            endcase
         end
         default: v = 32'(blk) + $urandom_range(0, span);
      endcase
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   // Result side: random stall bursts, plus one long hold-off on request
   initial begin : result_side
      bit hold_done;
      forever begin
         @(posedge clock);
         if (hold_off && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int unsigned   n;
      int unsigned   span;
      int unsigned   sat_mid;
      logic [2:0]    ori;
      logic [15:0]   blk;
      logic [24:0]   g;
      logic [16:0]   sat;
      logic [7:0]    mx;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: unit gain, single-pixel frames
      send_pixel(16'd0);
      send_pixel(16'd1);
      send_pixel(16'd255);
      send_pixel(16'd256);
      send_pixel(16'hFFFF);
      send_pixel(16'h5555);
      send_pixel(16'hAAAA);
      drain();

      // Oversized frame, both flips, a large negative gain, black at full scale
      configure(3'd6, 13'd8191, 13'd4096, 16'hFFFF, 25'h1000001, 17'd65536, 8'd255);
      send_pixel(16'hFFFF);
      send_pixel(16'd0);
      send_pixel(16'h8000);
      drain();

      // Zero width and a shrunk height mid-frame; everything saturates; zero clamp
      configure(3'd7, 13'd0, 13'd2, 16'd0, 25'h0FFFFFF, 17'd0, 8'd0);
      send_pixel(16'd0);
      send_pixel(16'd12345);
      send_pixel(16'hFFFF);
      drain();

      // Below black, saturation edges; a write to an unused address is ignored
      configure(3'd1, 13'd3, 13'd2, 16'd1000, 25'd21845, 17'd40000, 8'd200);
      csr_write(UNUSED_REG_ADDR, 32'hFFFF_FFFF);
      send_pixel(16'd999);
      send_pixel(16'd1000);
      send_pixel(16'd39999);
      send_pixel(16'd40000);
      send_pixel(16'hFFFF);
      drain();

      // Half gain for round-half-up; saturation above the pixel range
      configure(3'd0, 13'd2, 13'd2, 16'd0, 25'd32768, 17'h1FFFF, 8'd255);
      send_pixel(16'd1);
      send_pixel(16'd3);
      send_pixel(16'd0);
      send_pixel(16'hFFFF);
      drain();

      // Random phases: new settings, then a run of pixels
      while (pixels_sent < PIXEL_COUNT) begin
         ori  = (phases_run < 13) ? 3'(phases_run - 5) : 3'($urandom_range(0, 7));
         span = $urandom_range(0, 1) ? $urandom_range(1, 255) : $urandom_range(1, 65535);
         blk  = 16'($urandom_range(0, 65535));
         case ($urandom_range(0, 9))
            0:       g = 25'($urandom_range(0, 33554431));
            1:       g = '0;
            default: g = 25'((32'd255 << 16) / span);
         endcase
         sat_mid = blk + span / 2;
         case ($urandom_range(0, 5))
            0:       sat = 17'($urandom_range(0, 131071));
            1:       sat = (sat_mid > 65536) ? 17'd65536 : 17'(sat_mid);
            default: sat = 17'd65536;
         endcase
         mx = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(0, 255));
         configure(ori, pick_dim(), pick_dim(), blk, g, sat, mx);

         if (pixels_sent + CALM_TAIL > PIXEL_COUNT) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end else begin
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
         end
         // Hold the result side off while pixels keep coming, so the pipe backs up
         if (phases_run == 8) begin
            gaps_on  = 1'b0;
            hold_off = 1'b1;
         end

         n = $urandom_range(10, 60);
         repeat (n) send_pixel(pick_pixel(blk, span, sat));
         drain();
      end

      repeat (8) @(posedge clock);
      $display("Ran %0d pixels over %0d register settings;", pixels_sent, phases_run);
      $display("%0d results checked, %0d frames closed.", results_seen, frames_seen);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("pixel_window_level_orient_top test passed");
      end else begin
         $display("pixel_window_level_orient_top test failed");
      end
      $finish;
   end

endmodule
